// File: rtl/cis_pkg.sv
// cis_pkg: shared types and constants for the compacting id set.
// Used by cis_ctrl, cis_cell and compacting_id_set; depends on nothing.
package cis_pkg;

  localparam int ID_W    = 32;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int POS_SPAN = 64;

  localparam logic [ID_W-1:0] RESERVED_RST = '1;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DEL  = 2'd1,
    MODE_FIND = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic accept;   // request beat taken this cycle
    logic capture;  // cell compare results registered this cycle
    logic execute;  // state update and result this cycle
  } ctl_t;

  // register index bit (paddr[2]) of reserved_id
  localparam logic CFG_ADDR_RESERVED = 1'b0;

endpackage

// File: rtl/cis_ctrl.sv
// cis_ctrl: request sequencer (accept, compare, execute) for the id set.
// Depends on cis_pkg.
module cis_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output cis_pkg::ctl_t ctl
);
  import cis_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CMP;
      end
      ST_CMP:  state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    ctl.accept  = 1'b0;
    ctl.capture = 1'b0;
    ctl.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      ST_CMP:  ctl.capture = 1'b1;
      ST_EXEC: ctl.execute = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: rtl/cis_cell.sv
// cis_cell: one stored id slot with its own comparator and read gate.
// Takes a new id, or its upper neighbour's id on a delete shift. Depends on cis_pkg.
module cis_cell (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    shift,
  input  logic [cis_pkg::ID_W-1:0] new_id,
  input  logic [cis_pkg::ID_W-1:0] nbr_in,
  input  logic [cis_pkg::ID_W-1:0] cmp_id,
  input  logic                    live,
  input  logic                    sel,
  output logic [cis_pkg::ID_W-1:0] entry,
  output logic                    hit,
  output logic [cis_pkg::ID_W-1:0] rd
);
  import cis_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= new_id;
    end else if (shift) begin
      entry <= nbr_in;
    end
  end

  assign hit = live && (entry == cmp_id);
  assign rd  = (live && sel) ? entry : '0;

endmodule

// File: rtl/compacting_id_set.sv
// compacting_id_set: top level, a row of id cells with a sequencer and result register.
// Depends on cis_pkg, cis_ctrl and cis_cell.
//
//  channel   | handshake              | beat contents
//  ----------+------------------------+-----------------------------------------
//  request   | start in, busy out     | mode, id, position
//  result    | done out (one cycle)   | status, found, id_out, entry_count
//  config    | APB psel/penable/...   | reserved_id at byte address 0
//
// A request passes through three steps: the accept cycle, a compare cycle in which
// every cell checks its id against the request and gates its entry for a
// read, and an execute cycle that updates the row and registers the result.
// done is high in the cycle after execute, when busy is already low, so the
// next request may be accepted while the result is shown. busy stays high
// through compare and execute, so a request is taken only after the last has executed.
// rst (synchronous) empties the set and restores reserved_id to all ones;
// the cell contents are left as they are. The receiver cannot stall.
module compacting_id_set #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // request
  input  logic                      start,
  output logic                      busy,
  input  cis_pkg::mode_t            mode,
  input  logic signed [cis_pkg::ID_W-1:0]  id,
  input  logic [cis_pkg::POS_W-1:0] position,
  // result
  output logic                      done,
  output logic                      status,
  output logic                      found,
  output logic signed [cis_pkg::ID_W-1:0]  id_out,
  output logic [cis_pkg::CNT_W-1:0] entry_count,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import cis_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0] CAP = CW'(MAX_ENTRIES);

  // ---------------------------------------------------------------- config
  logic [ID_W-1:0] reserved_id;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_id <= RESERVED_RST;
    end else if (psel && penable && pwrite && paddr[2] == CFG_ADDR_RESERVED) begin
      reserved_id <= pwdata;
    end
  end

  assign prdata = (paddr[2] == CFG_ADDR_RESERVED) ? reserved_id : '0;

  // ------------------------------------------------------------- sequencer
  ctl_t ctl;

  cis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // request register
  mode_t           req_mode;
  logic [ID_W-1:0] req_id;
  logic [POS_W-1:0] req_pos;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_mode <= mode;
      req_id   <= id;
      req_pos  <= position;
    end
  end

  // ------------------------------------------------------------ cell row
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [ID_W-1:0] entry  [MAX_ENTRIES];
  logic [ID_W-1:0] rd     [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit;
  logic [MAX_ENTRIES-1:0] live;
  logic [MAX_ENTRIES-1:0] sel;
  logic [MAX_ENTRIES-1:0] load;
  logic [MAX_ENTRIES-1:0] shift;

  logic add_ok;
  logic del_ok;
  logic [IW-1:0] at;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ID_W-1:0] nbr;

    if (i + 1 < MAX_ENTRIES) begin : g_nbr
      assign nbr = entry[i+1];
    end else begin : g_last
      assign nbr = '0;
    end

    assign live[i]  = count > CW'(i);
    assign sel[i]   = (i < POS_SPAN) && (req_pos == POS_W'(i));
    assign load[i]  = ctl.execute && add_ok && (count == CW'(i));
    // on a delete every cell from the hit upwards takes its neighbour's id
    assign shift[i] = ctl.execute && del_ok && (IW'(i) >= at);

    cis_cell u_cell (
      .clk    (clk),
      .load   (load[i]),
      .shift  (shift[i]),
      .new_id (req_id),
      .nbr_in (nbr),
      .cmp_id (req_id),
      .live   (live[i]),
      .sel    (sel[i]),
      .entry  (entry[i]),
      .hit    (hit[i]),
      .rd     (rd[i])
    );
  end

  // ------------------------------------------------ compare-cycle capture
  logic [ID_W-1:0]        rd_any;
  logic                   rd_ok;
  logic [MAX_ENTRIES-1:0] hit_r;
  logic [ID_W-1:0]        rd_r;
  logic                   rd_ok_r;

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      rd_any = rd_any | rd[k];
    end
  end

  assign rd_ok = |(live & sel);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit_r   <= hit;
      rd_r    <= rd_any;
      rd_ok_r <= rd_ok;
    end
  end

  // ids are distinct, so at most one hit: OR of the hit indices gives its place
  always_comb begin
    at = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (hit_r[k]) at = at | IW'(k);
    end
  end

  // --------------------------------------------------------- execute step
  logic any_hit;
  logic st_v;
  logic found_v;
  logic [ID_W-1:0] out_v;

  assign any_hit = |hit_r;
  assign add_ok  = (req_mode == MODE_ADD) && (req_id != reserved_id) &&
                   (count < CAP) && !any_hit;
  assign del_ok  = (req_mode == MODE_DEL) && any_hit;

  always_comb begin
    count_next = count;
    st_v       = 1'b0;
    found_v    = 1'b0;
    out_v      = reserved_id;
    unique case (req_mode)
      MODE_ADD: begin
        if (add_ok) count_next = count + CW'(1);
        else        st_v = 1'b1;
      end
      MODE_DEL: begin
        if (del_ok) count_next = count - CW'(1);
        else        st_v = 1'b1;
      end
      MODE_FIND: found_v = any_hit;
      MODE_READ: begin
        if (rd_ok_r) out_v = rd_r;
        else         st_v = 1'b1;
      end
      default: st_v = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= ctl.execute;
      if (ctl.execute) count <= count_next;
    end
  end

  // result register, held until the next execute step
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status      <= st_v;
      found       <= found_v;
      id_out      <= out_v;
      entry_count <= CNT_W'(count_next);
    end
  end

endmodule

// File: tb/tb_compacting_id_set.sv
`timescale 1ns / 100ps
// tb_compacting_id_set: self-checking bench for the compacting id set.
// Depends on cis_pkg and compacting_id_set; a directed table, then random phases per marker.
module tb_compacting_id_set;
  import cis_pkg::*;

  localparam int SET_DEPTH      = 64;
  localparam int PHASE_ITEMS    = 125;
  localparam int POOL_SIZE      = 48;
  // Longest quiet spell in a correct run is a sender gap plus a request, or an APB
  // transfer plus the drain; this is many times that.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [2:0] ADDR_RESERVED = 3'd0;
  localparam logic [2:0] ADDR_SPARE    = 3'd4;   // register index 1: writes ignored

  typedef struct packed {
    logic              status;
    logic              found;
    logic [ID_W-1:0]   id_out;
    logic [CNT_W-1:0]  entry_count;
  } outcome_t;

  // One request beat, optionally with a literal expectation typed into the table.
  typedef struct packed {
    mode_t             op;
    logic [ID_W-1:0]   key;
    logic [POS_W-1:0]  pos;
    logic              literal;
    outcome_t          want;
  } request_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  mode_t                   mode = MODE_ADD;
  logic signed [ID_W-1:0]  id = '0;
  logic [POS_W-1:0]        position = '0;
  logic                    done;
  logic                    status;
  logic                    found;
  logic signed [ID_W-1:0]  id_out;
  logic [CNT_W-1:0]        entry_count;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [2:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  // Travel with each request beat so the monitor knows which expectation to queue.
  logic                    check_literal = 1'b0;
  outcome_t                literal_outcome = '0;

  // Shadow of the id set: the predictor's own copy of the block state.
  logic [ID_W-1:0]         set_ids [SET_DEPTH];
  int                      set_size = 0;
  logic [ID_W-1:0]         marker_id = RESERVED_RST;

  outcome_t                pending_outcomes [$];
  request_t                directed_steps [$];
  logic [ID_W-1:0]         key_pool [POOL_SIZE];
  int                      error_count = 0;
  int                      idle_cycles = 0;

  always #6 clk = ~clk;

  compacting_id_set #(.MAX_ENTRIES(SET_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .mode(mode), .id(id), .position(position),
    .done(done), .status(status), .found(found), .id_out(id_out),
    .entry_count(entry_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Slot holding key among the valid entries, or set_size when absent.
  function automatic int slot_of(logic [ID_W-1:0] key);
    for (int k = 0; k < set_size; k++)
      if (set_ids[k] == key) return k;
    return set_size;
  endfunction

  // Applies one request to the shadow set and returns the result it should give.
  function automatic outcome_t apply_request(mode_t op, logic [ID_W-1:0] key,
                                             logic [POS_W-1:0] pos);
    outcome_t res;
    int at;
    res = '{status: 1'b0, found: 1'b0, id_out: marker_id, entry_count: '0};
    case (op)
      MODE_ADD: begin
        // marker, duplicate and full are all rejected without touching the set
        if (key == marker_id || set_size >= SET_DEPTH || slot_of(key) < set_size) begin
          res.status = 1'b1;
        end else begin
          set_ids[set_size] = key;
          set_size++;
        end
      end
      MODE_DEL: begin
        at = slot_of(key);
        if (at >= set_size) begin
          res.status = 1'b1;
        end else begin
          // close the hole: later entries move down one place
          for (int k = at; k + 1 < set_size; k++) set_ids[k] = set_ids[k + 1];
          set_size--;
        end
      end
      MODE_FIND: res.found = (slot_of(key) < set_size);
      default: begin
        if (int'(pos) < set_size) res.id_out = set_ids[pos];
        else res.status = 1'b1;
      end
    endcase
    res.entry_count = set_size[CNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on request acceptance, checks each done beat in order,
  // tracks marker writes and runs the watchdog. Done is checked before the
  // push so a result shown in the accept cycle of the next request pairs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t predicted;
    logic progress;
    if (!rst) begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        if (pending_outcomes.size() == 0) begin
          $error("result beat with no request outstanding");
          error_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, status);
            error_count++;
          end
          if (found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, found);
            error_count++;
          end
          if (id_out !== want.id_out) begin
            $error("id_out: expected %h, got %h", want.id_out, id_out);
            error_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        predicted = apply_request(mode, id, position);
        pending_outcomes.push_back(check_literal ? literal_outcome : predicted);
      end
      if (psel && penable && pready) begin
        progress = 1'b1;
        if (pwrite && paddr[2] == ADDR_RESERVED[2]) marker_id = pwdata;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. All tasks are entered just after a rising edge.
  // ---------------------------------------------------------------------------

  // Holds the beat until the edge at which busy is low.
  task automatic issue(input request_t r);
    start <= 1'b1;
    mode <= r.op;
    id <= r.key;
    position <= r.pos;
    check_literal <= r.literal;
    literal_outcome <= r.want;
    do @(posedge clk); while (busy);
  endtask

  // Gap between bursts; start stays high when there is none.
  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Waits for every outstanding result, then for the pipeline to settle.
  task automatic drain_to_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // prdata is sampled at the edge that completes the access phase.
  task automatic reg_read_check(input logic [2:0] addr, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %h, got %h", want, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic request_t make_step(mode_t op, logic [ID_W-1:0] key,
                                         logic [POS_W-1:0] pos, logic literal,
                                         logic st, logic fd, logic [CNT_W-1:0] cnt);
    request_t r;
    r.op = op;
    r.key = key;
    r.pos = pos;
    r.literal = literal;
    // literal rows never expect a hit on read, so id_out is the reset marker
    r.want = '{status: st, found: fd, id_out: RESERVED_RST, entry_count: cnt};
    return r;
  endfunction

  // Random request. Keys are drawn from the stored set, the current marker, a
  // small pool (so duplicates and misses recur) or fresh values.
  function automatic request_t random_step(int add_w, int del_w, int find_w);
    request_t r;
    int pick;
    int stored_pct;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < add_w) r.op = MODE_ADD;
    else if (pick < add_w + del_w) r.op = MODE_DEL;
    else if (pick < add_w + del_w + find_w) r.op = MODE_FIND;
    else r.op = MODE_READ;
    case (r.op)
      MODE_ADD:  stored_pct = 15;
      MODE_DEL:  stored_pct = 65;
      MODE_FIND: stored_pct = 45;
      default:   stored_pct = 10;
    endcase
    pick = $urandom_range(0, 99);
    if (set_size > 0 && pick < stored_pct)
      r.key = set_ids[$urandom_range(0, set_size - 1)];
    else if (pick < stored_pct + 8)
      r.key = marker_id;
    else if ($urandom_range(0, 1) == 0)
      r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else
      r.key = $urandom;
    // mostly in-range positions, sometimes anywhere in the 6-bit span
    if (set_size > 0 && $urandom_range(0, 9) < 7)
      r.pos = POS_W'($urandom_range(0, set_size - 1));
    else
      r.pos = POS_W'($urandom_range(0, POS_SPAN - 1));
    return r;
  endfunction

  // Bursts of back-to-back beats with random gaps; about a third of the gaps
  // are zero so long unbroken stretches occur too.
  task automatic run_phase(input int add_w, input int del_w, input int find_w);
    int left;
    int burst;
    left = PHASE_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && left > 0; k++) begin
        issue(random_step(add_w, del_w, find_w));
        left--;
      end
      pause(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ID_W-1:0] new_marker;
    int add_w;
    int del_w;
    int find_w;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = 32'h0000_0001;
    key_pool[5] = 32'hffff_fffe;
    for (int k = 6; k < POOL_SIZE; k++) key_pool[k] = $urandom;

    // Directed table. Literal rows are plain reads of the rules: empty set, the
    // first adds, rejected add or delete, read past the count. The rest use the predictor.
    directed_steps.push_back(make_step(MODE_READ, 32'h0, 6'd0, 1, 1, 0, 0));
    directed_steps.push_back(make_step(MODE_FIND, 32'h0, 6'd0, 1, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_DEL, 32'h5, 6'd63, 1, 1, 0, 0));
    directed_steps.push_back(make_step(MODE_ADD, RESERVED_RST, 6'd0, 1, 1, 0, 0));
    directed_steps.push_back(make_step(MODE_ADD, 32'h7fff_ffff, 6'd0, 1, 0, 0, 1));
    directed_steps.push_back(make_step(MODE_ADD, 32'h8000_0000, 6'd63, 1, 0, 0, 2));
    directed_steps.push_back(make_step(MODE_ADD, 32'h0, 6'd0, 1, 0, 0, 3));
    directed_steps.push_back(make_step(MODE_ADD, 32'h7fff_ffff, 6'd0, 1, 1, 0, 3));
    directed_steps.push_back(make_step(MODE_FIND, 32'h8000_0000, 6'd63, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_READ, 32'hffff_ffff, 6'd1, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_READ, 32'h0, 6'd63, 1, 1, 0, 3));
    directed_steps.push_back(make_step(MODE_READ, 32'h0, 6'd3, 1, 1, 0, 3));
    // delete from the head: the two later entries move down
    directed_steps.push_back(make_step(MODE_DEL, 32'h7fff_ffff, 6'd0, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_READ, 32'h0, 6'd0, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_READ, 32'h0, 6'd1, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_FIND, 32'h7fff_ffff, 6'd0, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_DEL, 32'h7fff_ffff, 6'd0, 1, 1, 0, 2));
    directed_steps.push_back(make_step(MODE_ADD, 32'h5555_5555, 6'd0, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_ADD, 32'haaaa_aaaa, 6'd0, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_READ, 32'h0, 6'd3, 0, 0, 0, 0));
    // delete from the middle, then look at what slid into its place
    directed_steps.push_back(make_step(MODE_DEL, 32'h5555_5555, 6'd0, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_READ, 32'h0, 6'd2, 0, 0, 0, 0));
    directed_steps.push_back(make_step(MODE_FIND, 32'haaaa_aaaa, 6'd0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // marker must read back its reset value before anything is written
    reg_read_check(ADDR_RESERVED, RESERVED_RST);

    foreach (directed_steps[k]) begin
      issue(directed_steps[k]);
      pause($urandom_range(0, 2));
    end
    check_literal <= 1'b0;

    // Phase 0 keeps the reset marker and is weighted to adds so the set fills. Later phases
    // change the marker while ids are stored, including to one of those ids.
    run_phase(80, 5, 8);
    for (int ph = 1; ph < 6; ph++) begin
      drain_to_idle();
      case (ph)
        1: begin new_marker = 32'h0000_0000; add_w = 30; del_w = 30; find_w = 20; end
        2: begin new_marker = 32'h7fff_ffff; add_w = 15; del_w = 60; find_w = 10; end
        3: begin new_marker = 32'h8000_0000; add_w = 80; del_w = 5;  find_w = 8;  end
        4: begin
          new_marker = (set_size > 0) ? set_ids[0] : $urandom;
          add_w = 35; del_w = 25; find_w = 25;
        end
        default: begin new_marker = 32'hffff_ffff; add_w = 40; del_w = 30; find_w = 15; end
      endcase
      reg_write(ADDR_RESERVED, new_marker);
      reg_read_check(ADDR_RESERVED, new_marker);
      if (ph == 1) begin
        // a write to a register index other than 0 must leave the marker alone
        reg_write(ADDR_SPARE, $urandom);
        reg_read_check(ADDR_RESERVED, new_marker);
      end
      run_phase(add_w, del_w, find_w);
    end

    drain_to_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
